>>> sv/apt2d_pkg.sv
// Shared types, constants and tables of the 2D affine point transform.
// Holds the CORDIC arctangent table, register indexes and the coefficient struct.
// Has no dependencies; every other file of the block depends on it.
`default_nettype none

package apt2d_pkg;

  localparam int COORD_W       = 32;
  localparam int ANG_W         = 26;
  localparam int FRAC_BITS_DEF = 16;
  localparam int HALF_TURN_DEG = 180;

  // Cosine and sine are kept as signed Q2.30.
  localparam int CS_W    = 32;
  localparam int CS_FRAC = 30;
  localparam int K_W     = 2 * CS_W;
  localparam int K_HALF  = K_W / 2;

  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = $clog2((ANG_W > CORDIC_STEPS) ? ANG_W : CORDIC_STEPS);
  localparam int ATAN_W       = 37;
  localparam int Z_W          = 39;

  localparam logic signed [CS_W-1:0] CORDIC_GAIN  = 32'sd652032874;
  localparam logic signed [30:0]     NANO_PER_DEG = 31'sd1000000000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_ANGLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y        = 3'd4;

  // Products of the trigonometric terms with the scale factors, Q2.30 times Q(FRAC).
  typedef struct packed {
    logic signed [K_W-1:0] k_cx;  // cos * scale_x
    logic signed [K_W-1:0] k_sy;  // sin * scale_y
    logic signed [K_W-1:0] k_sx;  // sin * scale_x
    logic signed [K_W-1:0] k_cy;  // cos * scale_y
  } coef_t;

  // Arctangent of 2^-i in nanodegrees.
  function automatic logic [ATAN_W-1:0] atan_ndeg(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      5'd0:    val = 37'd45000000000;
      5'd1:    val = 37'd26565051177;
      5'd2:    val = 37'd14036243468;
      5'd3:    val = 37'd7125016349;
      5'd4:    val = 37'd3576334375;
      5'd5:    val = 37'd1789910608;
      5'd6:    val = 37'd895173710;
      5'd7:    val = 37'd447614171;
      5'd8:    val = 37'd223810500;
      5'd9:    val = 37'd111905677;
      5'd10:   val = 37'd55952892;
      5'd11:   val = 37'd27976453;
      5'd12:   val = 37'd13988227;
      5'd13:   val = 37'd6994114;
      5'd14:   val = 37'd3497057;
      5'd15:   val = 37'd1748528;
      5'd16:   val = 37'd874264;
      5'd17:   val = 37'd437132;
      5'd18:   val = 37'd218566;
      5'd19:   val = 37'd109283;
      5'd20:   val = 37'd54642;
      5'd21:   val = 37'd27321;
      5'd22:   val = 37'd13660;
      5'd23:   val = 37'd6830;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

>>> sv/apt2d_if.sv
// Valid/ready channel interfaces for points entering and leaving the block.
// Depends on apt2d_pkg for the coordinate width.
`default_nettype none

interface apt2d_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [apt2d_pkg::COORD_W-1:0] point_x;
  logic signed [apt2d_pkg::COORD_W-1:0] point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface apt2d_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [apt2d_pkg::COORD_W-1:0] out_x;
  logic signed [apt2d_pkg::COORD_W-1:0] out_y;
  logic                                 overflowed;

  modport source (output valid, out_x, out_y, overflowed, input ready);
  modport sink   (input valid, out_x, out_y, overflowed, output ready);
endinterface

`default_nettype wire

>>> sv/apt2d_trig.sv
// Coefficient unit: reduces the angle, runs the CORDIC and forms the four
// cos/sin times scale products with one shared multiplier. Depends on apt2d_pkg.
`default_nettype none

module apt2d_trig #(
  parameter int FRAC_BITS = apt2d_pkg::FRAC_BITS_DEF
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      restart_i,
  input  wire  logic signed [apt2d_pkg::ANG_W-1:0] angle_i,
  input  wire  logic signed [apt2d_pkg::COORD_W-1:0] scale_x_i,
  input  wire  logic signed [apt2d_pkg::COORD_W-1:0] scale_y_i,
  output apt2d_pkg::coef_t                         coef_o,
  output logic                                     busy_o
);
  import apt2d_pkg::*;

  localparam int FULL_W = FRAC_BITS + 9;
  localparam int RED_W  = FULL_W + 1;
  localparam int NANO_W = RED_W + 31;

  // A full turn is 45 << (FRAC_BITS + 3); whole turns are counted with a
  // reciprocal of 45 scaled by 2^32, which is exact for any 26-bit operand.
  localparam int TURN_ODD = (2 * HALF_TURN_DEG) / 8;
  localparam int QSH      = FRAC_BITS + 3;
  localparam int RECIP_SH = 32;
  localparam int QP_W     = ANG_W + RECIP_SH;
  localparam logic [RECIP_SH-1:0] RECIP =
    RECIP_SH'(((64'd1 << RECIP_SH) + 64'(TURN_ODD - 1)) / 64'(TURN_ODD));

  localparam logic [FULL_W-1:0] FULL      = FULL_W'(2 * HALF_TURN_DEG) << FRAC_BITS;
  localparam logic [RED_W-1:0]  FULL_R    = RED_W'(2 * HALF_TURN_DEG) << FRAC_BITS;
  localparam logic [RED_W-1:0]  HALF_R    = RED_W'(HALF_TURN_DEG) << FRAC_BITS;
  localparam logic [RED_W-1:0]  QUARTER_R = RED_W'(HALF_TURN_DEG / 2) << FRAC_BITS;
  localparam logic [NANO_W-1:0] TRUNC_BIAS = (NANO_W'(1) << FRAC_BITS) - NANO_W'(1);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_LOAD  = 11'b000_0000_0010,
    ST_QUOT  = 11'b000_0000_0100,
    ST_MOD   = 11'b000_0000_1000,
    ST_WRAP  = 11'b000_0001_0000,
    ST_FOLD  = 11'b000_0010_0000,
    ST_NANO  = 11'b000_0100_0000,
    ST_TRUNC = 11'b000_1000_0000,
    ST_ROT   = 11'b001_0000_0000,
    ST_SIGN  = 11'b010_0000_0000,
    ST_PROD  = 11'b100_0000_0000
  } trig_state_e;

  trig_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic [ANG_W-1:0]         mag_q, mag_d;
  logic                     neg_q, neg_d;
  logic [ANG_W-1:0]         quot_q, quot_d;
  logic signed [RED_W-1:0]  r_q, r_d;
  logic                     flip_q, flip_d;
  logic signed [NANO_W-1:0] nano_q, nano_d;
  logic signed [Z_W-1:0]    z_q, z_d;
  logic signed [CS_W-1:0]   x_q, x_d, y_q, y_d;
  logic signed [CS_W-1:0]   c_q, c_d, s_q, s_d;
  logic signed [K_W-1:0]    k_q [4];

  logic [QP_W-1:0]          quot_prod;
  logic [ANG_W-1:0]         turns;
  logic [FULL_W-1:0]        rem;
  logic [FULL_W-1:0]        r_pos;
  logic signed [RED_W-1:0]  r_pos_s;
  logic signed [NANO_W-1:0] nano_biased;
  logic signed [NANO_W-1:0] nano_shift;
  logic signed [Z_W-1:0]    atan_s;
  logic signed [CS_W-1:0]   dx, dy;
  logic signed [CS_W-1:0]   mul_a, mul_b;
  logic signed [K_W-1:0]    mul_p;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    quot_d  = quot_q;
    r_d     = r_q;
    flip_d  = flip_q;
    nano_d  = nano_q;
    z_d     = z_q;
    x_d     = x_q;
    y_d     = y_q;
    c_d     = c_q;
    s_d     = s_q;

    quot_prod   = QP_W'(mag_q >> QSH) * QP_W'(RECIP);
    turns       = (quot_q * ANG_W'(TURN_ODD)) << QSH;
    rem         = FULL_W'(mag_q);
    r_pos       = (neg_q && (rem != '0)) ? FULL - rem : rem;
    r_pos_s     = $signed({1'b0, r_pos});
    nano_biased = nano_q + (nano_q[NANO_W-1] ? $signed(TRUNC_BIAS) : '0);
    nano_shift  = nano_biased >>> FRAC_BITS;
    atan_s      = $signed({{(Z_W - ATAN_W){1'b0}}, atan_ndeg(step_q)});
    dx          = y_q >>> step_q;
    dy          = x_q >>> step_q;
    mul_a       = (step_q[1] ^ step_q[0]) ? s_q : c_q;
    mul_b       = step_q[0] ? scale_y_i : scale_x_i;
    mul_p       = mul_a * mul_b;

    case (state_q)
      ST_IDLE: begin
      end
      ST_LOAD: begin
        neg_d   = angle_i[ANG_W-1];
        mag_d   = angle_i[ANG_W-1] ? ANG_W'(0) - angle_i : angle_i;
        step_d  = '0;
        state_d = ST_QUOT;
      end
      ST_QUOT: begin
        quot_d  = quot_prod[QP_W-1:RECIP_SH];
        state_d = ST_MOD;
      end
      ST_MOD: begin
        // Removing the whole turns leaves the magnitude modulo a full turn.
        mag_d   = mag_q - turns;
        state_d = ST_WRAP;
      end
      ST_WRAP: begin
        if (r_pos_s > $signed(HALF_R)) begin
          r_d = r_pos_s - $signed(FULL_R);
        end else begin
          r_d = r_pos_s;
        end
        state_d = ST_FOLD;
      end
      ST_FOLD: begin
        // Beyond a quarter turn the angle moves by a half turn and the result flips sign.
        flip_d = 1'b0;
        if (r_q > $signed(QUARTER_R)) begin
          r_d    = r_q - $signed(HALF_R);
          flip_d = 1'b1;
        end else if (r_q < -$signed(QUARTER_R)) begin
          r_d    = r_q + $signed(HALF_R);
          flip_d = 1'b1;
        end
        state_d = ST_NANO;
      end
      ST_NANO: begin
        nano_d  = r_q * NANO_PER_DEG;
        state_d = ST_TRUNC;
      end
      ST_TRUNC: begin
        z_d     = nano_shift[Z_W-1:0];
        x_d     = CORDIC_GAIN;
        y_d     = '0;
        step_d  = '0;
        state_d = ST_ROT;
      end
      ST_ROT: begin
        if (!z_q[Z_W-1]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_s;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_s;
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        c_d     = flip_q ? -x_q : x_q;
        s_d     = flip_q ? -y_q : y_q;
        step_d  = '0;
        state_d = ST_PROD;
      end
      ST_PROD: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(3)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    if (restart_i) begin
      state_d = ST_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    quot_q <= quot_d;
    r_q    <= r_d;
    flip_q <= flip_d;
    nano_q <= nano_d;
    z_q    <= z_d;
    x_q    <= x_d;
    y_q    <= y_d;
    c_q    <= c_d;
    s_q    <= s_d;
    if (state_q == ST_PROD) begin
      k_q[step_q[1:0]] <= mul_p;
    end
  end

  assign coef_o.k_cx = k_q[0];
  assign coef_o.k_sy = k_q[1];
  assign coef_o.k_sx = k_q[2];
  assign coef_o.k_cy = k_q[3];
  assign busy_o      = (state_q != ST_IDLE);

endmodule

`default_nettype wire

>>> sv/apt2d_pipe.sv
// Five-stage point datapath: translate, split multiply, combine, align, saturate.
// Depends on apt2d_pkg and the channel interfaces in apt2d_if.sv.
`default_nettype none

module apt2d_pipe #(
  parameter int FRAC_BITS = apt2d_pkg::FRAC_BITS_DEF
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire  logic signed [apt2d_pkg::COORD_W-1:0] shift_x_i,
  input  wire  logic signed [apt2d_pkg::COORD_W-1:0] shift_y_i,
  input  wire  apt2d_pkg::coef_t                     coef_i,
  input  wire                                        busy_i,
  apt2d_in_if.sink                                   in_if,
  apt2d_out_if.source                                out_if
);
  import apt2d_pkg::*;

  localparam int SH   = CS_FRAC + FRAC_BITS;
  localparam int W_W  = COORD_W + 1;
  localparam int PL_W = K_HALF + 1 + W_W;
  localparam int PH_W = K_HALF + W_W;
  localparam int LD_W = PL_W + 1;
  localparam int HD_W = PH_W + 1;
  localparam int T_W  = HD_W + K_HALF;
  localparam int UP_W = T_W - SH - COORD_W + 1;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  logic signed [W_W-1:0]  u1_q, w1_q;
  logic signed [PL_W-1:0] pl_q [4];
  logic signed [PH_W-1:0] ph_q [4];
  logic signed [PL_W-1:0] pl_d [4];
  logic signed [PH_W-1:0] ph_d [4];
  logic signed [K_W-1:0]  kk   [4];
  logic signed [W_W-1:0]  op   [4];
  logic signed [HD_W-1:0] hx_q, hy_q;
  logic signed [LD_W-1:0] lx_q, ly_q;
  logic signed [T_W-1:0]  tx_q, ty_q;
  logic signed [COORD_W-1:0] ox_q, oy_q;
  logic                      ovf_q;
  logic [COORD_W:0]          sat_x, sat_y;

  // Saturating floor shift; bit COORD_W of the result flags saturation.
  function automatic logic [COORD_W:0] sat_shift(input logic signed [T_W-1:0] t);
    logic [UP_W-1:0] upper;
    logic [COORD_W:0] res;
    upper = t[T_W-1:SH+COORD_W-1];
    if ((&upper) || !(|upper)) begin
      res = {1'b0, t[SH+COORD_W-1:SH]};
    end else if (t[T_W-1]) begin
      res = {1'b1, 1'b1, {(COORD_W - 1){1'b0}}};
    end else begin
      res = {1'b1, 1'b0, {(COORD_W - 1){1'b1}}};
    end
    return res;
  endfunction

  // A stage takes new data when it is empty or its successor moves on.
  always_comb begin
    en5 = !v5_q || out_if.ready;
    en4 = !v4_q || en5;
    en3 = !v3_q || en4;
    en2 = !v2_q || en3;
    en1 = !v1_q || en2;
  end

  assign in_if.ready = en1 && !busy_i;

  always_comb begin
    kk[0] = coef_i.k_cx;
    kk[1] = coef_i.k_sy;
    kk[2] = coef_i.k_sx;
    kk[3] = coef_i.k_cy;
    op[0] = u1_q;
    op[1] = w1_q;
    op[2] = u1_q;
    op[3] = w1_q;
    for (int j = 0; j < 4; j++) begin
      pl_d[j] = $signed({1'b0, kk[j][K_HALF-1:0]}) * op[j];
      ph_d[j] = $signed(kk[j][K_W-1:K_HALF]) * op[j];
    end
    sat_x = sat_shift(tx_q);
    sat_y = sat_shift(ty_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_if.valid && in_if.ready;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      u1_q <= W_W'(in_if.point_x) + W_W'(shift_x_i);
      w1_q <= W_W'(in_if.point_y) + W_W'(shift_y_i);
    end
    if (en2) begin
      for (int j = 0; j < 4; j++) begin
        pl_q[j] <= pl_d[j];
        ph_q[j] <= ph_d[j];
      end
    end
    if (en3) begin
      hx_q <= HD_W'(ph_q[0]) - HD_W'(ph_q[1]);
      lx_q <= LD_W'(pl_q[0]) - LD_W'(pl_q[1]);
      hy_q <= HD_W'(ph_q[2]) + HD_W'(ph_q[3]);
      ly_q <= LD_W'(pl_q[2]) + LD_W'(pl_q[3]);
    end
    if (en4) begin
      tx_q <= (T_W'(hx_q) <<< K_HALF) + T_W'(lx_q);
      ty_q <= (T_W'(hy_q) <<< K_HALF) + T_W'(ly_q);
    end
    if (en5) begin
      ox_q  <= sat_x[COORD_W-1:0];
      oy_q  <= sat_y[COORD_W-1:0];
      ovf_q <= sat_x[COORD_W] || sat_y[COORD_W];
    end
  end

  assign out_if.valid      = v5_q;
  assign out_if.out_x      = ox_q;
  assign out_if.out_y      = oy_q;
  assign out_if.overflowed = ovf_q;

endmodule

`default_nettype wire

>>> sv/affine_point_transform_2d_unit.sv
// Top level of the 2D affine point transform: configuration registers,
// coefficient unit and point datapath. Depends on apt2d_pkg, apt2d_if.sv,
// apt2d_trig and apt2d_pipe.
//
// Each accepted point (x, y) in signed fixed point leaves as
// x' = c*sx*(x+tx) - s*sy*(y+ty), y' = s*sx*(x+tx) + c*sy*(y+ty), saturated to
// 32 bits with a flag when either coordinate clips. The block takes one point
// per cycle while the coefficient unit is idle and the datapath is not stalled;
// each accepted point passes through the register stages of the datapath, and
// every stage stalls only when it is full and its successor is blocked. Cosine
// and sine times the scale factors are computed once per configuration by a
// separate sequential unit: after reset and after each write to rotation_angle,
// scale_x or scale_y it runs 24 CORDIC steps, four passes through one shared
// multiplier and eight steps of setup, among them a reciprocal multiplication
// that wraps the angle; in_if.ready stays low while it runs. Writes to shift_x
// and shift_y take effect at once. Unknown register indexes are ignored.
`default_nettype none

module affine_point_transform_2d_unit #(
  parameter int FRAC_BITS = apt2d_pkg::FRAC_BITS_DEF
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       cfg_we_i,
  input  wire  logic [apt2d_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  logic [apt2d_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  apt2d_in_if.sink                                  in_if,
  apt2d_out_if.source                               out_if
);
  import apt2d_pkg::*;

  localparam logic [COORD_W-1:0] SCALE_ONE = COORD_W'(1) << FRAC_BITS;

  logic signed [ANG_W-1:0]   angle_q;
  logic signed [COORD_W-1:0] scale_x_q, scale_y_q, shift_x_q, shift_y_q;
  logic                      restart;
  logic                      busy;
  coef_t                     coef;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q   <= '0;
      scale_x_q <= SCALE_ONE;
      scale_y_q <= SCALE_ONE;
      shift_x_q <= '0;
      shift_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROTATION_ANGLE: angle_q   <= cfg_data_i[ANG_W-1:0];
        CFG_SCALE_X:        scale_x_q <= cfg_data_i[COORD_W-1:0];
        CFG_SCALE_Y:        scale_y_q <= cfg_data_i[COORD_W-1:0];
        CFG_SHIFT_X:        shift_x_q <= cfg_data_i[COORD_W-1:0];
        CFG_SHIFT_Y:        shift_y_q <= cfg_data_i[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The coefficients depend on the angle and both scale factors.
  assign restart = cfg_we_i && ((cfg_idx_i == CFG_ROTATION_ANGLE) ||
                                (cfg_idx_i == CFG_SCALE_X) ||
                                (cfg_idx_i == CFG_SCALE_Y));

  apt2d_trig #(
    .FRAC_BITS (FRAC_BITS)
  ) u_trig (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .angle_i   (angle_q),
    .scale_x_i (scale_x_q),
    .scale_y_i (scale_y_q),
    .coef_o    (coef),
    .busy_o    (busy)
  );

  apt2d_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_x_i (shift_x_q),
    .shift_y_i (shift_y_q),
    .coef_i    (coef),
    .busy_i    (busy),
    .in_if     (in_if),
    .out_if    (out_if)
  );

endmodule

`default_nettype wire
